// ===== rtl/spitx_pkg.sv =====
// ----------------------------------------------------------------------------
// spitx_pkg
// Operation, push status and send phase codes shared by the transmit queue.
// ----------------------------------------------------------------------------
package spitx_pkg;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_status;
    typedef logic [1:0] t_phase;

    localparam t_op OP_PUSH  = 2'd0;
    localparam t_op OP_TICK  = 2'd1;
    localparam t_op OP_FETCH = 2'd2;

    localparam t_status ST_NONE      = 2'd0;
    localparam t_status ST_COMMITTED = 2'd1;
    localparam t_status ST_DROP_FULL = 2'd2;
    localparam t_status ST_DROP_LEN  = 2'd3;

    localparam t_phase PH_IDLE   = 2'd0;
    localparam t_phase PH_ACTIVE = 2'd1;
    localparam t_phase PH_WAIT   = 2'd2;

endpackage

// ===== rtl/spi_tx_packet_queue_sequencer.sv =====
// ----------------------------------------------------------------------------
// spi_tx_packet_queue_sequencer
// Ring of fixed-length packet slots in one byte-wide memory, feeding a
// three-phase transmit sequencer (idle, transfer active, wait shifter idle).
// ----------------------------------------------------------------------------
// One item is taken per clock while the result register is free or being
// taken, so the block sustains one beat per cycle; each result is registered
// and appears in the cycle after its item. The packet store is a single
// memory of QUEUE_SLOTS * PACKET_BYTES bytes with one write port (pushes) and
// one read port (fetches) whose data is registered with the rest of the result.
// A push only writes the slot at the head, a fetch only reads the slot at the
// tail while a transfer is under way, and those two slots never coincide, so
// no forwarding is needed. The store is not cleared after reset: only slots
// holding a committed packet are ever read. A result held by downstream stall
// stalls the input side.
module spi_tx_packet_queue_sequencer
    import spitx_pkg::*;
#(
    parameter int PACKET_BYTES = 64,
    parameter int QUEUE_SLOTS  = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // item channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_data_byte,
    input  logic       i_packet_last,
    input  logic [5:0] i_byte_offset,
    input  logic       i_transfer_done,
    input  logic       i_shifter_busy,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_push_status,
    output logic [7:0] o_fetched_byte,
    output logic       o_start_transfer,
    output logic       o_chip_select_active,
    output logic       o_queue_full,
    output logic       o_queue_empty,
    output logic [1:0] o_phase_now
);

    localparam int DEPTH = QUEUE_SLOTS * PACKET_BYTES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = $clog2(QUEUE_SLOTS);
    localparam int FW    = $clog2(PACKET_BYTES + 2);

    localparam logic [SW-1:0] LAST_SLOT = SW'(QUEUE_SLOTS - 1);
    localparam logic [FW-1:0] FILL_SAT  = FW'(PACKET_BYTES + 1);
    localparam logic [FW-1:0] FILL_PKT  = FW'(PACKET_BYTES);

    // state
    logic [SW-1:0] r_head, n_head;
    logic [SW-1:0] r_tail, n_tail;
    logic [FW-1:0] r_fill, n_fill;
    logic          r_disc, n_disc;
    t_phase        r_phase, n_phase;

    // result register
    logic          r_out_valid;
    t_status       r_status, n_status;
    logic          r_start, n_start;
    logic          r_fetch_ok;
    logic          r_full, r_empty;
    t_phase        r_phase_out;

    // packet store
    logic [7:0]    mem [DEPTH];
    logic [7:0]    r_rd_data;
    logic          mem_we;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          fetch_ok;

    logic          in_acc;
    logic          full_now;
    logic          disc_eff;
    logic [FW-1:0] total;
    logic [SW-1:0] head_inc;
    logic [SW-1:0] tail_inc;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign head_inc = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
    assign tail_inc = (r_tail == LAST_SLOT) ? '0 : r_tail + 1'b1;
    assign full_now = (head_inc == r_tail);

    // the full test is made on the first byte only
    assign disc_eff = r_disc || ((r_fill == '0) && full_now);
    assign total    = (r_fill == FILL_SAT) ? r_fill : r_fill + 1'b1;

    assign wr_addr = AW'(AW'(r_head) * AW'(PACKET_BYTES)) + AW'(r_fill);
    assign rd_addr = AW'(AW'(r_tail) * AW'(PACKET_BYTES)) + AW'(i_byte_offset);

    assign fetch_ok = (r_phase inside {PH_ACTIVE, PH_WAIT})
                   && (32'(i_byte_offset) < PACKET_BYTES);

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_fill   = r_fill;
        n_disc   = r_disc;
        n_phase  = r_phase;
        n_status = ST_NONE;
        n_start  = 1'b0;
        mem_we   = 1'b0;
        case (i_operation)
            OP_PUSH: begin
                mem_we = !disc_eff && (32'(r_fill) < PACKET_BYTES);
                if (i_packet_last) begin
                    if (total != FILL_PKT) begin
                        n_status = ST_DROP_LEN;
                    end else if (disc_eff) begin
                        n_status = ST_DROP_FULL;
                    end else begin
                        n_head   = head_inc;
                        n_status = ST_COMMITTED;
                    end
                    n_fill = '0;
                    n_disc = 1'b0;
                end else begin
                    n_fill = total;
                    n_disc = disc_eff;
                end
            end
            OP_TICK: begin
                case (r_phase)
                    PH_ACTIVE: begin
                        if (i_transfer_done) begin
                            n_phase = PH_WAIT;
                        end
                    end
                    PH_WAIT: begin
                        if (!i_shifter_busy) begin
                            n_tail  = tail_inc;
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        if (r_head != r_tail) begin
                            n_phase = PH_ACTIVE;
                            n_start = 1'b1;
                        end
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_disc      <= 1'b0;
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_fill  <= n_fill;
                r_disc  <= n_disc;
                r_phase <= n_phase;
            end
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted item
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status    <= n_status;
            r_start     <= n_start;
            r_fetch_ok  <= (i_operation == OP_FETCH) && fetch_ok;
            r_full      <= ((n_head == LAST_SLOT) ? '0 : n_head + 1'b1) == n_tail;
            r_empty     <= (n_head == n_tail);
            r_phase_out <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && mem_we) begin
            mem[wr_addr] <= i_data_byte;
        end
    end

    // read only on a valid fetch so the data holds while the result is stalled
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_operation == OP_FETCH) && fetch_ok) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_push_status        = r_status;
    assign o_fetched_byte       = r_fetch_ok ? r_rd_data : 8'd0;
    assign o_start_transfer     = r_start;
    assign o_chip_select_active = (r_phase_out != PH_IDLE);
    assign o_queue_full         = r_full;
    assign o_queue_empty        = r_empty;
    assign o_phase_now          = r_phase_out;

    // a slot under transfer is never the slot being filled
    a_send_slot_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ACTIVE || r_phase == PH_WAIT) |-> (r_head != r_tail))
        else $error("transfer in progress with empty ring");

    a_start_phase : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_start_transfer) |-> (o_phase_now == PH_ACTIVE))
        else $error("start pulse outside active phase");

    a_commit_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_push_status == ST_COMMITTED) |-> !o_queue_empty)
        else $error("committed packet but ring reports empty");

    a_release_slot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_operation == OP_TICK && r_phase == PH_WAIT && !i_shifter_busy)
        |=> (r_tail != $past(r_tail)))
        else $error("slot not released on shifter idle");

endmodule

// ===== tb/tb_spi_tx_packet_queue_sequencer.sv =====
// ----------------------------------------------------------------------------
// tb_spi_tx_packet_queue_sequencer
// Self-checking bench for the packet ring and transmit sequencer. Items are
// queued up front: a short directed list, then a flood that fills the ring,
// then random rounds of whole packets mixed with ticks and fetches. A local
// model of the ring predicts one result per accepted item. Every result beat
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_spi_tx_packet_queue_sequencer;
    import spitx_pkg::*;

    localparam int   PKT_BYTES      = 64;
    localparam int   N_ITEMS        = 1850;
    localparam int   QUIET_TAIL     = 200;
    localparam int   WATCHDOG_LIMIT = 1000;
    localparam t_op  OP_NONE        = 2'd3;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic       last;
        logic [5:0] ofs;
        logic       done;
        logic       busy;
        logic       hold;   // wait for all results before sending this one
    } t_tx_item;

    typedef struct packed {
        t_status    status;
        logic [7:0] fetched;
        logic       start;
        logic       cs;
        logic       full;
        logic       empty;
        t_phase     phase;
    } t_tx_result;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       out_stall = 1'b0;
    t_tx_item   cur_item  = '0;

    logic       o_in_stall;
    logic       o_out_valid;
    logic [1:0] o_push_status;
    logic [7:0] o_fetched_byte;
    logic       o_start_transfer;
    logic       o_chip_select_active;
    logic       o_queue_full;
    logic       o_queue_empty;
    logic [1:0] o_phase_now;

    t_tx_item   pending_items[$];
    t_tx_result expected_results[$];
    int         stim_count  = 0;
    int         fail_count  = 0;
    int         idle_cycles = 0;

    // ring model
    logic [2:0] slot_head  = '0;
    logic [2:0] slot_tail  = '0;
    logic [6:0] fill_count = '0;
    logic       dropping   = 1'b0;
    t_phase     tx_phase   = PH_IDLE;
    logic [7:0] slot_mem [0:511];

    always #6 clk = ~clk;

    spi_tx_packet_queue_sequencer u_top (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .o_in_stall           (o_in_stall),
        .i_operation          (cur_item.op),
        .i_data_byte          (cur_item.data),
        .i_packet_last        (cur_item.last),
        .i_byte_offset        (cur_item.ofs),
        .i_transfer_done      (cur_item.done),
        .i_shifter_busy       (cur_item.busy),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (out_stall),
        .o_push_status        (o_push_status),
        .o_fetched_byte       (o_fetched_byte),
        .o_start_transfer     (o_start_transfer),
        .o_chip_select_active (o_chip_select_active),
        .o_queue_full         (o_queue_full),
        .o_queue_empty        (o_queue_empty),
        .o_phase_now          (o_phase_now)
    );

    function automatic t_tx_result advance_ring_model(t_tx_item it);
        t_tx_result r;
        int         total;
        r = '0;
        case (it.op)
            OP_PUSH: begin
                if (fill_count == 0 && !dropping && 3'(slot_head + 3'd1) == slot_tail) begin
                    dropping = 1'b1;
                end
                if (!dropping && fill_count < PKT_BYTES) begin
                    slot_mem[{slot_head, fill_count[5:0]}] = it.data;
                end
                // count saturates one past a full packet
                total = (fill_count + 1 > PKT_BYTES + 1) ? PKT_BYTES + 1 : fill_count + 1;
                if (it.last) begin
                    if (total != PKT_BYTES) begin
                        r.status = ST_DROP_LEN;
                    end else if (dropping) begin
                        r.status = ST_DROP_FULL;
                    end else begin
                        slot_head = slot_head + 3'd1;
                        r.status  = ST_COMMITTED;
                    end
                    fill_count = '0;
                    dropping   = 1'b0;
                end else begin
                    fill_count = 7'(total);
                end
            end
            OP_TICK: begin
                case (tx_phase)
                    PH_ACTIVE: begin
                        if (it.done) tx_phase = PH_WAIT;
                    end
                    PH_WAIT: begin
                        if (!it.busy) begin
                            slot_tail = slot_tail + 3'd1;
                            tx_phase  = PH_IDLE;
                        end
                    end
                    default: begin
                        tx_phase = PH_IDLE;
                        if (slot_head != slot_tail) begin
                            tx_phase = PH_ACTIVE;
                            r.start  = 1'b1;
                        end
                    end
                endcase
            end
            OP_FETCH: begin
                if (tx_phase == PH_ACTIVE || tx_phase == PH_WAIT) begin
                    r.fetched = slot_mem[{slot_tail, it.ofs}];
                end
            end
            default: ;
        endcase
        r.cs    = (tx_phase != PH_IDLE);
        r.full  = (3'(slot_head + 3'd1) == slot_tail);
        r.empty = (slot_head == slot_tail);
        r.phase = tx_phase;
        return r;
    endfunction

    function automatic t_tx_item make_item(t_op op, logic [7:0] data, logic last,
                                           logic [5:0] ofs, logic done, logic busy);
        t_tx_item it;
        it.op   = op;
        it.data = data;
        it.last = last;
        it.ofs  = ofs;
        it.done = done;
        it.busy = busy;
        it.hold = 1'b0;
        return it;
    endfunction

    function automatic t_tx_item any_item(t_op op);
        return make_item(op, 8'($urandom), 1'($urandom), 6'($urandom),
                         1'($urandom), 1'($urandom));
    endfunction

    // tick or fetch; fetch offsets lean towards both ends of the slot
    function automatic t_tx_item control_item();
        t_tx_item it;
        if ($urandom_range(0, 2) == 0) begin
            it = any_item(OP_FETCH);
            case ($urandom_range(0, 3))
                0: it.ofs = 6'd0;
                1: it.ofs = 6'd63;
                default: ;
            endcase
        end else begin
            it = any_item(OP_TICK);
        end
        return it;
    endfunction

    function automatic int pick_length();
        case ($urandom_range(0, 19))
            0: return PKT_BYTES - 1;
            1: return PKT_BYTES + 1;
            2: return $urandom_range(1, PKT_BYTES - 2);
            3: return $urandom_range(PKT_BYTES + 2, 140);
            default: return PKT_BYTES;
        endcase
    endfunction

    task automatic add_item(t_tx_item it);
        pending_items.push_back(it);
        if (it.op != OP_NONE) stim_count++;
    endtask

    task automatic add_packet(int len, bit chatter);
        t_tx_item it;
        for (int i = 0; i < len; i++) begin
            if (chatter && $urandom_range(0, 15) == 0) add_item(control_item());
            it      = any_item(OP_PUSH);
            it.last = (i == len - 1);
            add_item(it);
        end
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // driver
    logic tx_jittery = 1'b0;
    int   tx_gap     = 0;
    int   tx_mode_left = 0;

    always @(posedge clk) begin
        t_tx_item nxt;
        logic     go;
        go  = 1'b0;
        nxt = cur_item;
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (in_valid && !o_in_stall) begin
                expected_results.push_back(advance_ring_model(cur_item));
            end
            if (tx_mode_left == 0) begin
                tx_jittery   = ($urandom_range(0, 2) != 0);
                tx_mode_left = $urandom_range(20, 150);
            end else begin
                tx_mode_left--;
            end
            if (!in_valid || !o_in_stall) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_items.size() != 0 &&
                             !(pending_items[0].hold && expected_results.size() != 0)) begin
                    if (tx_jittery && pending_items.size() > QUIET_TAIL &&
                        $urandom_range(0, 4) == 0) begin
                        tx_gap = $urandom_range(0, 2);
                    end else begin
                        nxt = pending_items.pop_front();
                        go  = 1'b1;
                    end
                end
                in_valid <= go;
                cur_item <= nxt;
            end
        end
    end

    // monitor and stall generator
    logic rx_jittery   = 1'b0;
    int   rx_stall     = 0;
    int   rx_mode_left = 0;

    always @(posedge clk) begin
        t_tx_result want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            rx_stall = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no item outstanding");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("push_status",        want.status,  o_push_status);
                    check_field("fetched_byte",       want.fetched, o_fetched_byte);
                    check_field("start_transfer",     want.start,   o_start_transfer);
                    check_field("chip_select_active", want.cs,      o_chip_select_active);
                    check_field("queue_full",         want.full,    o_queue_full);
                    check_field("queue_empty",        want.empty,   o_queue_empty);
                    check_field("phase_now",          want.phase,   o_phase_now);
                end
            end
            if (rx_mode_left == 0) begin
                rx_jittery   = ($urandom_range(0, 2) != 0);
                rx_mode_left = $urandom_range(20, 150);
            end else begin
                rx_mode_left--;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                out_stall <= 1'b1;
            end else if (rx_jittery && pending_items.size() > QUIET_TAIL &&
                         $urandom_range(0, 4) == 0) begin
                rx_stall = $urandom_range(0, 2);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_tx_item it;

        // directed: ignored op, fetch and tick while idle, short packets
        add_item(make_item(OP_NONE, 8'hFF, 1'b1, 6'd63, 1'b1, 1'b1));
        add_item(make_item(OP_NONE, 8'h00, 1'b0, 6'd0, 1'b0, 1'b0));
        add_item(make_item(OP_FETCH, 8'h00, 1'b0, 6'd0, 1'b0, 1'b0));
        add_item(make_item(OP_FETCH, 8'hFF, 1'b1, 6'd63, 1'b1, 1'b1));
        add_item(make_item(OP_TICK, 8'h00, 1'b0, 6'd0, 1'b1, 1'b0));
        add_item(make_item(OP_TICK, 8'hFF, 1'b1, 6'd63, 1'b0, 1'b1));
        add_item(make_item(OP_PUSH, 8'hFF, 1'b1, 6'd63, 1'b1, 1'b1));
        add_item(make_item(OP_PUSH, 8'h00, 1'b0, 6'd0, 1'b0, 1'b0));
        add_item(make_item(OP_PUSH, 8'hFF, 1'b1, 6'd0, 1'b0, 1'b0));

        // flood the ring: seven commit, the eighth is dropped as full and the
        // ninth is too long while full, so length wins
        repeat (8) add_packet(PKT_BYTES, 1'b0);
        add_packet(PKT_BYTES + 2, 1'b0);

        // sender holds off until every result is back, then walks one transfer
        it      = make_item(OP_TICK, 8'h5A, 1'b0, 6'd0, 1'b0, 1'b0);
        it.hold = 1'b1;
        add_item(it);
        add_item(make_item(OP_FETCH, 8'h00, 1'b0, 6'd0, 1'b0, 1'b0));
        add_item(make_item(OP_FETCH, 8'h00, 1'b0, 6'd63, 1'b0, 1'b0));
        add_item(make_item(OP_TICK, 8'h00, 1'b0, 6'd0, 1'b0, 1'b1));
        add_item(make_item(OP_TICK, 8'h00, 1'b0, 6'd0, 1'b1, 1'b1));
        add_item(make_item(OP_FETCH, 8'h00, 1'b0, 6'd31, 1'b0, 1'b0));
        add_item(make_item(OP_TICK, 8'h00, 1'b0, 6'd0, 1'b0, 1'b1));
        add_item(make_item(OP_TICK, 8'h00, 1'b0, 6'd0, 1'b0, 1'b0));

        // random rounds: a few packets, then a stretch of ticks and fetches, sometimes followed by ignored ops
        while (stim_count < N_ITEMS) begin
            repeat ($urandom_range(1, 5)) add_packet(pick_length(), 1'b1);
            it      = control_item();
            it.hold = ($urandom_range(0, 5) == 0);
            add_item(it);
            repeat ($urandom_range(4, 60)) add_item(control_item());
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 3)) add_item(any_item(OP_NONE));
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        do begin
            @(posedge clk);
        end while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (8) @(posedge clk);

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/spitx_pkg.sv
rtl/spi_tx_packet_queue_sequencer.sv
tb/tb_spi_tx_packet_queue_sequencer.sv
